FILE: sv/gfdl_pkg.sv
// Package for the carrier-aided FLL/DLL tracking loop filter.
// Holds shared types, function codes, CORDIC arctangent table and helpers.
// No dependencies.
`default_nettype none
package gfdl_pkg;

    localparam int CordicSteps = 16;   // valid 8..24
    localparam int AtanEntries = 24;
    localparam int StepW = $clog2(AtanEntries + 1);

    typedef enum logic [2:0] {
        F_DISCR = 3'd0,
        F_FLL   = 3'd1,
        F_DLL   = 3'd2,
        F_ADJ   = 3'd3,
        F_INIT  = 3'd4
    } t_func;

    localparam logic [2:0] REG_DISCR_GAIN = 3'd0;
    localparam logic [2:0] REG_FLL_GAIN   = 3'd1;
    localparam logic [2:0] REG_PROP_GAIN  = 3'd2;
    localparam logic [2:0] REG_INT_GAIN   = 3'd3;
    localparam logic [2:0] REG_C2C        = 3'd4;

    // queued word from front to back
    typedef struct packed {
        logic [2:0]         func;
        logic signed [15:0] i_s;
        logic signed [15:0] q_s;
        logic signed [15:0] last_i;
        logic signed [15:0] last_q;
        logic               en;
        logic               hq;
        logic signed [31:0] carr;
        logic signed [31:0] code;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_CORD, S_ANG, S_PRODA, S_PRODB, S_SUM1,
        S_SUM2, S_OUTM, S_OUT
    } t_state;

    function automatic logic [31:0] atan_lut(input logic [StepW-1:0] k);
        logic [31:0] r;
        begin
            case (k)
                5'd0:  r = 32'd536870912;
                5'd1:  r = 32'd316933406;
                5'd2:  r = 32'd167458907;
                5'd3:  r = 32'd85004756;
                5'd4:  r = 32'd42667331;
                5'd5:  r = 32'd21354465;
                5'd6:  r = 32'd10679838;
                5'd7:  r = 32'd5340245;
                5'd8:  r = 32'd2670163;
                5'd9:  r = 32'd1335087;
                5'd10: r = 32'd667544;
                5'd11: r = 32'd333772;
                5'd12: r = 32'd166886;
                5'd13: r = 32'd83443;
                5'd14: r = 32'd41722;
                5'd15: r = 32'd20861;
                5'd16: r = 32'd10430;
                5'd17: r = 32'd5215;
                5'd18: r = 32'd2608;
                5'd19: r = 32'd1304;
                5'd20: r = 32'd652;
                5'd21: r = 32'd326;
                5'd22: r = 32'd163;
                5'd23: r = 32'd81;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        begin
            if (v > 66'sh7FFFFFFF) r = 32'sh7FFFFFFF;
            else if (v < -66'sh80000000) r = 32'sh80000000;
            else r = v[31:0];
            return r;
        end
    endfunction

endpackage
`default_nettype wire

FILE: sv/gfdl_front.sv
// Front end: accepts input words, captures the previous I/Q pair, queues commands.
// Depends on gfdl_pkg.
`default_nettype none
module gfdl_front import gfdl_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [2:0]         i_func,
    input  wire logic signed [15:0] i_i_sample,
    input  wire logic signed [15:0] i_q_sample,
    input  wire logic               i_discr_enable,
    input  wire logic               i_half_quadrant,
    input  wire logic signed [31:0] i_carr_value,
    input  wire logic signed [31:0] i_code_value,
    output logic                    o_cmd_valid,
    output t_cmd                    o_cmd,
    input  wire logic               i_cmd_pop
);
    t_cmd               r_q [2];
    logic               r_wp, r_rp;
    logic [1:0]         r_cnt;
    logic signed [15:0] r_last_i, r_last_q;
    logic               w_push;
    t_cmd               w_cmd;

    assign o_stall     = (r_cnt == 2'd2);
    assign w_push      = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        w_cmd.func   = i_func;
        w_cmd.i_s    = i_i_sample;
        w_cmd.q_s    = i_q_sample;
        w_cmd.last_i = r_last_i;
        w_cmd.last_q = r_last_q;
        w_cmd.en     = i_discr_enable;
        w_cmd.hq     = i_half_quadrant;
        w_cmd.carr   = i_carr_value;
        w_cmd.code   = i_code_value;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cmd;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
            r_last_i <= 16'sd32767; r_last_q <= 16'sd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_cmd_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_cmd_pop};
            // track the stored pair at the front so the queue carries it along
            if (w_push && i_func == F_DISCR) begin
                r_last_i <= i_i_sample; r_last_q <= i_q_sample;
            end else if (w_push && i_func == F_INIT) begin
                r_last_i <= 16'sd32767; r_last_q <= 16'sd0;
            end
        end
    end

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> (r_cnt != 2'd0)) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_ptrs_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> (r_wp == r_rp)) else $error("pointers differ on empty");
endmodule
`default_nettype wire

FILE: sv/gfdl_back.sv
// Back end: CORDIC atan2 and loop filter arithmetic over a sequencer.
// Depends on gfdl_pkg.
`default_nettype none
module gfdl_back import gfdl_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cmd_valid,
    input  wire t_cmd               i_cmd,
    output logic                    o_cmd_pop,
    input  wire logic [31:0]        i_discr_gain,
    input  wire logic [16:0]        i_fll_gain,
    input  wire logic [31:0]        i_prop_gain,
    input  wire logic [31:0]        i_int_gain,
    input  wire logic [23:0]        i_c2c,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_carrier_freq,
    output logic signed [31:0]      o_code_freq_out,
    output logic signed [31:0]      o_dll_error
);
    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic signed [33:0] r_x, r_y;          // dot/cross, 33 bits plus guard
    logic signed [49:0] r_cx, r_cy;        // CORDIC vectors, scaled by 2^16
    logic signed [33:0] r_z;
    logic [StepW-1:0]   r_k;
    logic               r_y0, r_xneg;
    logic signed [23:0] r_asum;
    logic signed [31:0] r_fvel, r_cfreq, r_cvel, r_kfreq;
    logic signed [65:0] r_pa, r_pb, r_pc;
    logic signed [31:0] r_err;
    logic signed [49:0] w_xs, w_ys;
    logic signed [33:0] w_at, w_xf, w_yf;
    logic signed [17:0] w_ang, w_a2;
    logic signed [24:0] w_sum;
    logic signed [65:0] w_dl;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_cmd_valid) begin
                case (i_cmd.func)
                    F_DISCR: n_state = i_cmd.en ? S_MUL1 : S_OUTM;
                    F_FLL, F_DLL, F_ADJ: n_state = S_PRODA;
                    default: n_state = S_OUTM;
                endcase
            end
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_CORD;
            S_CORD:  if (r_y0 || r_k == StepW'(CordicSteps - 1)) n_state = S_ANG;
            S_ANG:   n_state = S_OUTM;
            S_PRODA: n_state = S_PRODB;
            S_PRODB: n_state = S_SUM1;
            S_SUM1:  n_state = S_SUM2;
            S_SUM2:  n_state = S_OUTM;
            S_OUTM:  n_state = S_OUT;
            S_OUT:   if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
        o_valid   = (r_state == S_OUT);
    end

    assign w_xs = r_cx >>> r_k;
    assign w_ys = r_cy >>> r_k;
    assign w_at = {2'b00, atan_lut(r_k)};
    // finish dot and cross with the second pair of products
    assign w_xf = r_x + 34'(r_cmd.q_s * r_cmd.last_q);
    assign w_yf = r_y - 34'(r_cmd.i_s * r_cmd.last_q);

    always_comb begin
        w_ang = 18'((r_z + 34'sd32768) >>> 16);
        if (r_y0) w_ang = r_xneg ? 18'sd32768 : 18'sd0;
        if (w_ang > 18'sd32768) w_ang = 18'sd32768;
        if (w_ang < -18'sd32768) w_ang = -18'sd32768;
        w_a2 = w_ang;
        if (r_cmd.hq && (w_ang > 18'sd16384 || w_ang < -18'sd16384))
            w_a2 = (w_ang > 0) ? w_ang - 18'sd32768 : w_ang + 18'sd32768;
        w_sum = 25'(r_asum) + 25'(w_a2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_asum <= '0; r_fvel <= '0; r_cfreq <= '0; r_cvel <= '0; r_kfreq <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: if (i_cmd_valid) begin
                    r_cmd <= i_cmd;
                    if (i_cmd.func == F_INIT) begin
                        r_asum <= '0;
                        r_cfreq <= i_cmd.carr; r_fvel <= i_cmd.carr;
                        r_kfreq <= (i_c2c != 24'd0) ? 32'sd0 : i_cmd.code;
                        r_cvel  <= (i_c2c != 24'd0) ? 32'sd0 : i_cmd.code;
                    end
                end
                S_MUL1: begin
                    r_x <= 34'(r_cmd.i_s * r_cmd.last_i);
                    r_y <= 34'(r_cmd.last_i * r_cmd.q_s);
                end
                S_MUL2: begin
                    // pre-rotate by pi when x is negative, then scale by 2^16
                    r_k    <= '0;
                    r_y0   <= (w_yf == 34'sd0);
                    r_xneg <= w_xf[33];
                    if (w_xf[33]) begin
                        r_cx <= 50'(-w_xf) <<< 16; r_cy <= 50'(-w_yf) <<< 16;
                        r_z  <= w_yf[33] ? -34'sh80000000 : 34'sh80000000;
                    end else begin
                        r_cx <= 50'(w_xf) <<< 16; r_cy <= 50'(w_yf) <<< 16; r_z <= '0;
                    end
                end
                S_CORD: begin
                    r_k <= r_k + StepW'(1);
                    if (r_cy >= 0) begin
                        r_cx <= r_cx + w_ys; r_cy <= r_cy - w_xs; r_z <= r_z + w_at;
                    end else begin
                        r_cx <= r_cx - w_ys; r_cy <= r_cy + w_xs; r_z <= r_z - w_at;
                    end
                end
                S_ANG: begin
                    if (w_sum > 25'sd8388607) r_asum <= 24'sh7FFFFF;
                    else if (w_sum < -25'sd8388608) r_asum <= 24'sh800000;
                    else r_asum <= w_sum[23:0];
                end
                S_PRODA: begin
                    case (r_cmd.func)
                        F_FLL: r_pa <= 66'(r_asum * $signed({1'b0, i_discr_gain}));
                        F_DLL: r_pa <= 66'(r_cmd.code * $signed({1'b0, i_int_gain}));
                        default: r_pa <= 66'(r_cmd.carr * $signed({1'b0, i_c2c}));
                    endcase
                    r_pb <= 66'(r_cmd.code * $signed({1'b0, i_prop_gain}));
                    r_pc <= 66'(r_cfreq * $signed({1'b0, i_c2c}));
                end
                S_PRODB: begin
                    case (r_cmd.func)
                        F_FLL: begin
                            r_err <= sat32((r_pa + 66'sd32768) >>> 16);
                            r_asum <= '0;
                        end
                        F_DLL: r_cvel <= sat32(66'(r_cvel) + ((r_pa + 66'sd32768) >>> 16));
                        default: begin
                            r_cfreq <= sat32(66'(r_cfreq) + 66'(r_cmd.carr));
                            r_fvel  <= sat32(66'(r_fvel) + 66'(r_cmd.carr));
                            r_kfreq <= sat32(66'(r_kfreq) + ((r_pa + 66'sd8388608) >>> 24));
                        end
                    endcase
                end
                S_SUM1: if (r_cmd.func == F_FLL)
                    r_pa <= 66'(r_err * $signed({1'b0, i_fll_gain}));
                S_SUM2: begin
                    if (r_cmd.func == F_FLL) begin
                        r_fvel  <= sat32(66'(r_fvel) + ((r_pa + 66'sd32768) >>> 16));
                        r_cfreq <= sat32(66'(r_fvel) + ((r_pa + 66'sd32768) >>> 16));
                    end else if (r_cmd.func == F_DLL) begin
                        r_kfreq <= sat32(66'(r_cvel) + ((r_pb + 66'sd32768) >>> 16)
                                   + ((r_pc + 66'sd8388608) >>> 24));
                    end
                end
                // aiding product of the final carrier for the DLL error
                S_OUTM: r_pc <= 66'(r_cfreq * $signed({1'b0, i_c2c}));
                default: ;
            endcase
        end
    end

    // results read straight from the loop state, which holds while in S_OUT
    assign w_dl            = 66'(r_kfreq) - ((r_pc + 66'sd8388608) >>> 24);
    assign o_carrier_freq  = r_cfreq;
    assign o_code_freq_out = r_kfreq;
    assign o_dll_error     = sat32(w_dl);

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_carrier_freq)
            && $stable(o_code_freq_out) && $stable(o_dll_error)))
        else $error("result dropped while stalled");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == S_IDLE)) else $error("pop while busy");
    a_cordic_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CORD) |-> (r_k < StepW'(CordicSteps))) else $error("CORDIC overrun");
endmodule
`default_nettype wire

FILE: sv/gnss_fll_dll_tracking_loop.sv
// Top level of the carrier-aided FLL/DLL tracking loop filter.
// Depends on gfdl_pkg, gfdl_front and gfdl_back.
//
//  port group   dir  handshake          payload
//  input word   in   i_valid / o_stall  i_func .. i_code_value
//  result word  out  o_valid / i_stall  o_carrier_freq, o_code_freq_out, o_dll_error
//  config       in   i_cfg_we           i_cfg_index, i_cfg_data
//
// The back end takes a word from the queue while idle, then runs product, sum and
// output states for funcs 1..3; multiplies, 1 to 16 CORDIC steps, angle and output
// states for func 0 with the discriminator on, the longest path; else output only.
// A two-entry queue sits between front and back, so the front takes words while
// a result waits. Reset (synchronous, active low) clears loop state and registers.
`default_nettype none
module gnss_fll_dll_tracking_loop import gfdl_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [2:0]         i_func,
    input  wire logic signed [15:0] i_i_sample,
    input  wire logic signed [15:0] i_q_sample,
    input  wire logic               i_discr_enable,
    input  wire logic               i_half_quadrant,
    input  wire logic signed [31:0] i_carr_value,
    input  wire logic signed [31:0] i_code_value,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_carrier_freq,
    output logic signed [31:0]      o_code_freq_out,
    output logic signed [31:0]      o_dll_error,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);
    logic [31:0] r_discr_gain, r_prop_gain, r_int_gain;
    logic [16:0] r_fll_gain;
    logic [23:0] r_c2c;
    logic        w_cmd_valid, w_pop;
    t_cmd        w_cmd;

    // hold configuration; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_discr_gain <= '0; r_fll_gain <= '0; r_prop_gain <= '0;
            r_int_gain <= '0; r_c2c <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DISCR_GAIN: r_discr_gain <= i_cfg_data;
                REG_FLL_GAIN:   r_fll_gain   <= i_cfg_data[16:0];
                REG_PROP_GAIN:  r_prop_gain  <= i_cfg_data;
                REG_INT_GAIN:   r_int_gain   <= i_cfg_data;
                REG_C2C:        r_c2c        <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    gfdl_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_func, .i_i_sample, .i_q_sample,
        .i_discr_enable, .i_half_quadrant, .i_carr_value, .i_code_value,
        .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd), .i_cmd_pop(w_pop)
    );

    gfdl_back u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(w_cmd_valid), .i_cmd(w_cmd), .o_cmd_pop(w_pop),
        .i_discr_gain(r_discr_gain), .i_fll_gain(r_fll_gain), .i_prop_gain(r_prop_gain),
        .i_int_gain(r_int_gain), .i_c2c(r_c2c), .o_valid, .i_stall,
        .o_carrier_freq, .o_code_freq_out, .o_dll_error
    );
endmodule
`default_nettype wire
